>>> hw/rtl/spcp_pkg.sv
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared types, packet layout constants and the CRC-8 byte update for the
// sensor packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package spcp_pkg;

    localparam logic [3:0] PKT_LEN       = 4'd12;
    localparam logic [3:0] ID_LAST_IDX   = 4'd3;
    localparam logic [3:0] KIND_IDX      = 4'd4;
    localparam logic [3:0] TIME_LAST_IDX = 4'd6;
    localparam logic [3:0] CRC_IDX       = 4'd11;
    localparam logic [7:0] CRC_POLY      = 8'h31;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [31:0] device_id;
        logic [7:0]  measure_kind;
        logic [15:0] time_seconds;
        logic [31:0] meas_value;
        logic [7:0]  received_crc;
        logic        crc_error;
    } t_result;

    // CRC-8, MSB first, no reflection, one whole byte per call.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/spcp_in_reg.sv
// ----------------------------------------------------------------------------
// spcp_in_reg
// Input register that holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  spcp_pkg::t_in_item  i_item,
    output logic                o_stall,
    output logic                o_valid,
    output spcp_pkg::t_in_item  o_item,
    input  wire                 i_advance
);
    import spcp_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_advance_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |-> r_valid)
        else $error("input register advanced while empty");

endmodule

`default_nettype wire

>>> hw/rtl/spcp_assembler.sv
// ----------------------------------------------------------------------------
// spcp_assembler
// Byte counter, running CRC and field shift registers. Flags the CRC byte
// and presents the finished packet fields for it.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_assembler (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  spcp_pkg::t_in_item  i_item,
    input  wire                 i_take,
    output logic                o_emit,
    output spcp_pkg::t_result   o_result
);
    import spcp_pkg::*;

    logic [3:0]  r_count;
    logic [7:0]  r_crc;
    logic [31:0] r_id;
    logic [7:0]  r_kind;
    logic [15:0] r_time;
    logic [31:0] r_value;

    logic [3:0]  n_count;
    logic [7:0]  n_crc;
    logic [31:0] n_id;
    logic [7:0]  n_kind;
    logic [15:0] n_time;
    logic [31:0] n_value;

    logic        restart;
    logic [3:0]  idx;
    logic [7:0]  crc_base;

    assign restart  = i_item.frame_start || (r_count >= PKT_LEN);
    assign idx      = restart ? 4'd0 : r_count;
    assign crc_base = restart ? 8'd0 : r_crc;
    assign o_emit   = (idx == CRC_IDX);

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        n_id    = r_id;
        n_kind  = r_kind;
        n_time  = r_time;
        n_value = r_value;
        if (o_emit) begin
            n_count = 4'd0;
            n_crc   = 8'd0;
        end else begin
            n_count = idx + 4'd1;
            n_crc   = crc8_update(crc_base, i_item.data_byte);
            priority if (idx <= ID_LAST_IDX) begin
                n_id = {r_id[23:0], i_item.data_byte};
            end else if (idx == KIND_IDX) begin
                n_kind = i_item.data_byte;
            end else if (idx <= TIME_LAST_IDX) begin
                n_time = {r_time[7:0], i_item.data_byte};
            end else begin
                n_value = {r_value[23:0], i_item.data_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
            r_crc   <= 8'd0;
        end else if (i_take) begin
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_id    <= n_id;
            r_kind  <= n_kind;
            r_time  <= n_time;
            r_value <= n_value;
        end
    end

    always_comb begin
        o_result.device_id    = r_id;
        o_result.measure_kind = r_kind;
        o_result.time_seconds = r_time;
        o_result.meas_value   = r_value;
        o_result.received_crc = i_item.data_byte;
        o_result.crc_error    = (crc_base != i_item.data_byte);
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < PKT_LEN)
        else $error("byte count left the packet range");

    a_count_after_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_emit) |=> (r_count == 4'd0 && r_crc == 8'd0))
        else $error("count or CRC not cleared after the CRC byte");

endmodule

`default_nettype wire

>>> hw/rtl/spcp_out_reg.sv
// ----------------------------------------------------------------------------
// spcp_out_reg
// Result register that holds one finished packet until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_out_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  spcp_pkg::t_result   i_result,
    output logic                o_ready,
    output logic                o_valid,
    output spcp_pkg::t_result   o_result,
    input  wire                 i_stall
);
    import spcp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !i_load)
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

>>> hw/rtl/sensor_packet_crc8_parser.sv
// ----------------------------------------------------------------------------
// sensor_packet_crc8_parser
// Parses 12-byte sensor packets (id, kind, time, value, CRC-8 poly 0x31) and
// reports the fields with a CRC mismatch flag after the last byte.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_stall   i_data_byte, i_frame_start
//   out      output     o_out_valid / i_out_stall o_device_id .. o_crc_error
//
// One byte is accepted per cycle while o_in_stall is low; the CRC byte update is combinational.
// A result is loaded into the output register when its held CRC byte advances from the input register.
// Reset clears the byte count, the CRC and both valid flags.
// A stalled result holds; non-final bytes keep flowing while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_packet_crc8_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_frame_start,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [31:0] o_device_id,
    output logic [7:0]  o_measure_kind,
    output logic [15:0] o_time_seconds,
    output logic [31:0] o_meas_value,
    output logic [7:0]  o_received_crc,
    output logic        o_crc_error
);
    import spcp_pkg::*;

    t_in_item in_item;
    t_in_item held_item;
    t_result  asm_result;
    t_result  out_result;
    logic     held_valid;
    logic     emit;
    logic     out_ready;
    logic     advance;

    assign in_item.data_byte   = i_data_byte;
    assign in_item.frame_start = i_frame_start;

    assign advance = held_valid && (!emit || out_ready);

    spcp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (in_item),
        .o_stall   (o_in_stall),
        .o_valid   (held_valid),
        .o_item    (held_item),
        .i_advance (advance)
    );

    spcp_assembler u_assembler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (held_item),
        .i_take   (advance),
        .o_emit   (emit),
        .o_result (asm_result)
    );

    spcp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (asm_result),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result),
        .i_stall  (i_out_stall)
    );

    assign o_device_id    = out_result.device_id;
    assign o_measure_kind = out_result.measure_kind;
    assign o_time_seconds = out_result.time_seconds;
    assign o_meas_value   = out_result.meas_value;
    assign o_received_crc = out_result.received_crc;
    assign o_crc_error    = out_result.crc_error;

    a_result_follows_crc_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> o_out_valid)
        else $error("CRC byte consumed without a result");

endmodule

`default_nettype wire
